@@ rtl/smc_pkg.sv @@
// Shared types and constants for the satellite mode controller.
// No dependencies.
`timescale 1ns / 1ps

package smc_pkg;

  localparam logic [31:0] ClockEpoch = 32'd315532800;
  localparam logic [15:0] BatLowMv   = 16'd6500;

  typedef enum logic [2:0] {
    MODE_PREDEPLOY = 3'd0,
    MODE_DEPLOY    = 3'd1,
    MODE_STANDBY   = 3'd2,
    MODE_BEACON    = 3'd3,
    MODE_EDL       = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    OP_EVAL        = 3'd0,
    OP_TX_ENABLE   = 3'd1,
    OP_TX_DISABLE  = 3'd2,
    OP_EDL_ENABLE  = 3'd3,
    OP_EDL_DISABLE = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    REG_DEPLOY_TIMEOUT = 3'd0,
    REG_TX_TIMEOUT     = 3'd1,
    REG_EDL_WINDOW     = 3'd2,
    REG_RESET_TIMEOUT  = 3'd3,
    REG_MAX_ATTEMPTS   = 3'd4,
    REG_ACTUATION_TIME = 3'd5,
    REG_BOOT_SECONDS   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [31:0] deploy_timeout;
    logic [31:0] tx_timeout;
    logic [31:0] edl_window;
    logic [31:0] reset_timeout;
    logic [7:0]  max_attempts;
    logic [15:0] actuation_time;
    logic [31:0] boot_seconds;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] now_seconds;
    logic [15:0] vbatt_one;
    logic [15:0] vbatt_two;
  } item_t;

  typedef struct packed {
    mode_e       mode;
    logic        deployed;
    logic [7:0]  attempts;
    logic        battery_good;
    logic [31:0] tx_time;
    logic [31:0] edl_time;
  } state_t;

  typedef struct packed {
    mode_e       mode;
    logic        beacon_on;
    logic        deploy_fire;
    logic [15:0] deploy_duration;
    logic        hard_reset_req;
    logic        would_wait;
    logic        battery_ok;
  } result_t;

endpackage

@@ rtl/smc_eval.sv @@
// One pass of the mode switch: next state and result for one transaction.
// Depends on smc_pkg.
`timescale 1ns / 1ps

module smc_eval (
  input  smc_pkg::cfg_t    cfg_i,
  input  smc_pkg::state_t  state_i,
  input  smc_pkg::item_t   item_i,
  output smc_pkg::state_t  state_o,
  output smc_pkg::result_t result_o
);
  import smc_pkg::*;

  logic signed [32:0] tx_diff, edl_diff, boot_diff, epoch_diff;
  logic               tx_on, edl_on, rst_due, pre_wait, bat_ok;
  logic [31:0]        now;

  assign now        = item_i.now_seconds;
  assign tx_diff    = $signed({1'b0, now}) - $signed({1'b0, state_i.tx_time});
  assign edl_diff   = $signed({1'b0, now}) - $signed({1'b0, state_i.edl_time});
  assign boot_diff  = $signed({1'b0, now}) - $signed({1'b0, cfg_i.boot_seconds});
  assign epoch_diff = $signed({1'b0, now}) - $signed({1'b0, ClockEpoch});

  assign tx_on    = tx_diff < $signed({1'b0, cfg_i.tx_timeout});
  assign edl_on   = edl_diff < $signed({1'b0, cfg_i.edl_window});
  assign rst_due  = boot_diff >= $signed({1'b0, cfg_i.reset_timeout});
  assign pre_wait = epoch_diff < $signed({1'b0, cfg_i.deploy_timeout});
  assign bat_ok   = !((item_i.vbatt_one < BatLowMv) && (item_i.vbatt_two < BatLowMv));

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    case (item_i.op)
      OP_EVAL: begin
        case (state_i.mode)
          MODE_PREDEPLOY: begin
            if (pre_wait) begin
              state_o.tx_time     = now;
              result_o.would_wait = 1'b1;
            end else begin
              state_o.mode = MODE_DEPLOY;
            end
          end
          MODE_DEPLOY: begin
            if (!state_i.deployed && (state_i.attempts < cfg_i.max_attempts)) begin
              state_o.battery_good = bat_ok;
              if (bat_ok) begin
                result_o.deploy_fire     = 1'b1;
                result_o.deploy_duration = cfg_i.actuation_time;
                state_o.attempts         = state_i.attempts + 8'd1;
              end else begin
                result_o.would_wait = 1'b1;
              end
            end else begin
              state_o.mode     = MODE_STANDBY;
              state_o.deployed = 1'b1;
              state_o.attempts = '0;
            end
          end
          MODE_STANDBY: begin
            if (edl_on) begin
              state_o.mode = MODE_EDL;
            end else if (rst_due) begin
              result_o.hard_reset_req = 1'b1;
            end else if (tx_on) begin
              state_o.battery_good = bat_ok;
              if (bat_ok) begin
                state_o.mode = MODE_BEACON;
              end else begin
                result_o.would_wait = 1'b1;
              end
            end else begin
              result_o.would_wait = 1'b1;
            end
          end
          MODE_BEACON: begin
            result_o.beacon_on = 1'b1;
            if (edl_on) begin
              state_o.mode = MODE_EDL;
            end else if (rst_due) begin
              result_o.hard_reset_req = 1'b1;
            end else if (!tx_on) begin
              state_o.mode = MODE_STANDBY;
            end else begin
              state_o.battery_good = bat_ok;
              if (!bat_ok) begin
                state_o.mode = MODE_STANDBY;
              end else begin
                result_o.would_wait = 1'b1;
              end
            end
          end
          MODE_EDL: begin
            if (!edl_on) begin
              if (tx_on) begin
                state_o.battery_good = bat_ok;
                state_o.mode         = bat_ok ? MODE_BEACON : MODE_STANDBY;
              end else begin
                state_o.mode = MODE_STANDBY;
              end
            end else begin
              result_o.would_wait = 1'b1;
            end
          end
          default: begin
            state_o.mode = MODE_PREDEPLOY;
          end
        endcase
      end
      OP_TX_ENABLE:  state_o.tx_time = now;
      OP_TX_DISABLE: state_o.tx_time = '0;
      OP_EDL_ENABLE: begin
        if (state_i.mode != MODE_PREDEPLOY) state_o.edl_time = now;
      end
      OP_EDL_DISABLE: begin
        if (state_i.mode != MODE_PREDEPLOY) state_o.edl_time = '0;
      end
      default: ;
    endcase
    result_o.mode       = state_o.mode;
    result_o.battery_ok = state_o.battery_good;
  end

endmodule

@@ rtl/satellite_mode_controller_top.sv @@
// Accepted transactions go to item_q; results are registered in result_q.
// Throughput: one transaction per cycle; the input and result registers
// advance together, held only by the result side's ready.
// Reset (rst_ni, async low): predeploy mode, battery good, stamps, counters
// and all configuration registers cleared; both stages empty.
// Top level of the satellite mode controller; depends on smc_pkg, smc_eval.
`timescale 1ns / 1ps

module satellite_mode_controller_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [31:0] now_seconds_i,
  input  logic [15:0] vbatt_one_i,
  input  logic [15:0] vbatt_two_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  mode_o,
  output logic        beacon_on_o,
  output logic        deploy_fire_o,
  output logic [15:0] deploy_duration_o,
  output logic        hard_reset_req_o,
  output logic        would_wait_o,
  output logic        battery_ok_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import smc_pkg::*;

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  item_t   item_q;
  result_t result_q, result_d;
  logic    item_valid_q, out_valid_q;
  logic    advance, cfg_wr;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[4:2]))
        REG_DEPLOY_TIMEOUT: cfg_q.deploy_timeout <= pwdata;
        REG_TX_TIMEOUT:     cfg_q.tx_timeout     <= pwdata;
        REG_EDL_WINDOW:     cfg_q.edl_window     <= pwdata;
        REG_RESET_TIMEOUT:  cfg_q.reset_timeout  <= pwdata;
        REG_MAX_ATTEMPTS:   cfg_q.max_attempts   <= pwdata[7:0];
        REG_ACTUATION_TIME: cfg_q.actuation_time <= pwdata[15:0];
        REG_BOOT_SECONDS:   cfg_q.boot_seconds   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[4:2]))
      REG_DEPLOY_TIMEOUT: prdata = cfg_q.deploy_timeout;
      REG_TX_TIMEOUT:     prdata = cfg_q.tx_timeout;
      REG_EDL_WINDOW:     prdata = cfg_q.edl_window;
      REG_RESET_TIMEOUT:  prdata = cfg_q.reset_timeout;
      REG_MAX_ATTEMPTS:   prdata = {24'd0, cfg_q.max_attempts};
      REG_ACTUATION_TIME: prdata = {16'd0, cfg_q.actuation_time};
      REG_BOOT_SECONDS:   prdata = cfg_q.boot_seconds;
      default:            prdata = '0;
    endcase
  end

  // pipeline control
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !item_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= '{op: op_i, now_seconds: now_seconds_i,
                  vbatt_one: vbatt_one_i, vbatt_two: vbatt_two_i};
    end
  end

  smc_eval u_eval (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= '{mode: MODE_PREDEPLOY, deployed: 1'b0, attempts: 8'd0,
                        battery_good: 1'b1, tx_time: 32'd0, edl_time: 32'd0};
      out_valid_q  <= 1'b0;
    end else if (advance) begin
      out_valid_q <= item_valid_q;
      if (item_valid_q) state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && item_valid_q) result_q <= result_d;
  end

  assign out_valid_o       = out_valid_q;
  assign mode_o            = result_q.mode;
  assign beacon_on_o       = result_q.beacon_on;
  assign deploy_fire_o     = result_q.deploy_fire;
  assign deploy_duration_o = result_q.deploy_duration;
  assign hard_reset_req_o  = result_q.hard_reset_req;
  assign would_wait_o      = result_q.would_wait;
  assign battery_ok_o      = result_q.battery_ok;

  a_fire_in_deploy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.deploy_fire |-> result_q.mode == MODE_DEPLOY &&
      result_q.battery_ok && !result_q.would_wait)
    else $error("deploy fire outside deploy mode");

  a_dur_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !result_q.deploy_fire |-> result_q.deploy_duration == '0)
    else $error("deploy duration without fire");

  a_deployed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.deployed |=> state_q.deployed)
    else $error("deployed flag cleared");

  a_hreset_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.hard_reset_req |->
      !result_q.would_wait &&
      (result_q.mode == MODE_STANDBY || result_q.mode == MODE_BEACON))
    else $error("hard reset outside standby or beacon");

endmodule
